@@ rtl/core/strmi_pkg.sv @@
// ============================================================================
// Sparse-table range-minimum package
// Shared constants, command codes and the front-to-back command record.
// ============================================================================
package strmi_pkg;

    localparam int DefMaxPositions = 1024;
    localparam int DefValueBits    = 64;
    localparam int IdxW            = 11;
    localparam int CmdW            = 2;
    localparam int StatW           = 2;

    localparam logic [CmdW-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CmdW-1:0] CMD_BUILD = 2'd1;
    localparam logic [CmdW-1:0] CMD_QUERY = 2'd2;

    localparam logic [StatW-1:0] ST_OK      = 2'd0;
    localparam logic [StatW-1:0] ST_EMPTY   = 2'd1;
    localparam logic [StatW-1:0] ST_RANGE   = 2'd2;
    localparam logic [StatW-1:0] ST_NOBUILD = 2'd3;

    typedef enum logic [1:0] {
        OP_REPLY = 2'd0,
        OP_LOAD  = 2'd1,
        OP_BUILD = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        op_t              op;
        logic [StatW-1:0] status;
        logic [IdxW-1:0]  pos;
        logic [IdxW-1:0]  lo;
        logic [IdxW-1:0]  hi;
        logic [3:0]       lvl;
        logic [63:0]      value;
    } job_t;

    function automatic logic [3:0] flog2(input logic [IdxW-1:0] x);
        logic [3:0] r;
        r = '0;
        for (int b = 0; b < IdxW; b++) begin
            if (x[b]) begin
                r = 4'(b);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/strmi_front.sv @@
// ============================================================================
// Sparse-table front part
// Accepts items, checks them against the used count and the built mark and
// forms a job for the back part.
// ============================================================================
module strmi_front
    import strmi_pkg::*;
#(
    parameter int MAX_POSITIONS = DefMaxPositions,
    parameter int VALUE_BITS    = DefValueBits
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [IdxW-1:0]       cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CmdW-1:0]       in_cmd,
    input  logic [IdxW-1:0]       in_pos,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic [IdxW-1:0]       in_lo,
    input  logic [IdxW-1:0]       in_hi,
    output logic [IdxW-1:0]       used_count,
    output logic                  job_valid,
    input  logic                  job_ready,
    output job_t                  job
);

    localparam logic [IdxW-1:0] MaxPos = IdxW'(MAX_POSITIONS);

    logic [IdxW-1:0] used_reg;
    logic            built_reg;
    job_t            q_reg [2];
    logic [1:0]      cnt_reg;
    logic            wp_reg, rp_reg;
    job_t            j;
    logic            push, pop;

    assign used_count = used_reg;
    assign in_ready   = (cnt_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign pop        = job_valid && job_ready;
    assign job_valid  = (cnt_reg != 2'd0);
    assign job        = q_reg[rp_reg];

    always_comb begin
        j        = '0;
        j.pos    = in_pos;
        j.lo     = in_lo;
        j.hi     = in_hi;
        j.value  = 64'(signed'(in_value));
        j.lvl    = flog2(in_hi - in_lo + IdxW'(1));
        j.op     = OP_REPLY;
        j.status = ST_OK;
        case (in_cmd)
            CMD_LOAD: begin
                if (in_pos == '0 || in_pos > used_reg) begin
                    j.status = ST_RANGE;
                end else begin
                    j.op = OP_LOAD;
                end
            end
            CMD_BUILD: j.op = OP_BUILD;
            CMD_QUERY: begin
                if (!built_reg) begin
                    j.status = ST_NOBUILD;
                end else if (in_lo > in_hi) begin
                    j.status = ST_EMPTY;
                end else if (in_lo == '0 || in_hi > used_reg) begin
                    j.status = ST_RANGE;
                end else begin
                    j.op = OP_QUERY;
                end
            end
            default: j.op = OP_REPLY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= MaxPos;
            built_reg <= 1'b0;
            cnt_reg   <= '0;
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                built_reg <= 1'b0;
                if (cfg_wdata == '0) begin
                    used_reg <= IdxW'(1);
                end else if (cfg_wdata > MaxPos) begin
                    used_reg <= MaxPos;
                end else begin
                    used_reg <= cfg_wdata;
                end
            end else if (push && j.op == OP_LOAD) begin
                built_reg <= 1'b0;
            end else if (push && j.op == OP_BUILD) begin
                built_reg <= 1'b1;
            end
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (pop) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= j;
        end
    end

endmodule

@@ rtl/core/strmi_back.sv @@
// ============================================================================
// Sparse-table back part
// Holds the value and level memories, sweeps the levels on a build and
// answers queries with two lookups and a compare.
// ============================================================================
module strmi_back
    import strmi_pkg::*;
#(
    parameter int MAX_POSITIONS = DefMaxPositions,
    parameter int VALUE_BITS    = DefValueBits
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IdxW-1:0]       used_count,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  job_t                  job,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [IdxW-1:0]       out_index,
    output logic [VALUE_BITS-1:0] out_value,
    output logic [StatW-1:0]      out_status
);

    localparam int AW    = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int LW    = (AW > 1) ? $clog2(AW + 1) : 1;
    localparam int Depth = AW * MAX_POSITIONS;
    localparam int TW    = $clog2(Depth);

    typedef enum logic [3:0] {
        S_IDLE, S_B_RD, S_B_RV, S_B_CMP, S_Q_IDX, S_Q_VAL, S_Q_CMP, S_OUT
    } state_t;

    logic [VALUE_BITS-1:0] vmem [MAX_POSITIONS];
    logic [IdxW-1:0]       tmem [Depth];

    state_t              state_reg;
    logic [LW-1:0]       k_reg;
    logic [IdxW-1:0]     i_reg;
    logic [IdxW-1:0]     a_reg, b_reg;
    logic [VALUE_BITS-1:0] va_reg, vb_reg;
    logic [IdxW-1:0]     oi_reg;
    logic [VALUE_BITS-1:0] ov_reg;
    logic [StatW-1:0]    os_reg;
    logic [IdxW-1:0]     qlo_reg, qhi_reg;
    logic [3:0]          ql_reg;

    logic [TW-1:0]       ta, tb, qrow;
    logic [IdxW-1:0]     half, span, pb;
    logic [IdxW:0]       lastpos;
    logic                a_wins;
    logic [LW-1:0]       top;

    assign job_ready  = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign out_index  = oi_reg;
    assign out_value  = ov_reg;
    assign out_status = os_reg;

    assign top  = LW'(flog2(used_count));
    assign half = IdxW'(1) << (k_reg - LW'(1));
    assign span = IdxW'(1) << k_reg;
    assign lastpos = {1'b0, i_reg} + {1'b0, span};
    assign pb   = qhi_reg - (IdxW'(1) << ql_reg) + IdxW'(1);
    assign qrow = TW'((LW'(ql_reg) - LW'(1)) * MAX_POSITIONS);
    // Level k lives at row k-1; the previous level of a build is row k-2.
    assign ta = (state_reg == S_Q_IDX) ? qrow + TW'(qlo_reg - IdxW'(1))
              : TW'((k_reg - LW'(2)) * MAX_POSITIONS) + TW'(i_reg - IdxW'(1));
    assign tb = (state_reg == S_Q_IDX) ? qrow + TW'(pb - IdxW'(1))
              : TW'((k_reg - LW'(2)) * MAX_POSITIONS)
                + TW'(i_reg + half - IdxW'(1));
    assign a_wins = ($signed(va_reg) < $signed(vb_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        oi_reg  <= '0;
                        ov_reg  <= '0;
                        os_reg  <= job.status;
                        qlo_reg <= job.lo;
                        qhi_reg <= job.hi;
                        ql_reg  <= job.lvl;
                        case (job.op)
                            OP_LOAD: begin
                                vmem[AW'(job.pos - IdxW'(1))] <= job.value[VALUE_BITS-1:0];
                                state_reg <= S_OUT;
                            end
                            OP_BUILD: begin
                                k_reg <= LW'(1);
                                i_reg <= IdxW'(1);
                                state_reg <= (top == '0) ? S_OUT : S_B_RD;
                            end
                            OP_QUERY: state_reg <= S_Q_IDX;
                            default:  state_reg <= S_OUT;
                        endcase
                    end
                end
                S_B_RD: begin
                    if (lastpos > {1'b0, used_count} + 1'b1) begin
                        if (k_reg == top) begin
                            state_reg <= S_OUT;
                        end else begin
                            k_reg <= k_reg + LW'(1);
                            i_reg <= IdxW'(1);
                        end
                    end else begin
                        if (k_reg == LW'(1)) begin
                            a_reg <= i_reg;
                            b_reg <= i_reg + half;
                        end else begin
                            a_reg <= tmem[ta];
                            b_reg <= tmem[tb];
                        end
                        state_reg <= S_B_RV;
                    end
                end
                S_B_RV: begin
                    va_reg <= vmem[AW'(a_reg - IdxW'(1))];
                    vb_reg <= vmem[AW'(b_reg - IdxW'(1))];
                    state_reg <= S_B_CMP;
                end
                S_B_CMP: begin
                    tmem[TW'((k_reg - LW'(1)) * MAX_POSITIONS) + TW'(i_reg - IdxW'(1))]
                        <= a_wins ? a_reg : b_reg;
                    i_reg <= i_reg + IdxW'(1);
                    state_reg <= S_B_RD;
                end
                S_Q_IDX: begin
                    if (ql_reg == '0) begin
                        a_reg <= qlo_reg;
                        b_reg <= pb;
                    end else begin
                        a_reg <= tmem[ta];
                        b_reg <= tmem[tb];
                    end
                    state_reg <= S_Q_VAL;
                end
                S_Q_VAL: begin
                    va_reg <= vmem[AW'(a_reg - IdxW'(1))];
                    vb_reg <= vmem[AW'(b_reg - IdxW'(1))];
                    state_reg <= S_Q_CMP;
                end
                S_Q_CMP: begin
                    oi_reg <= a_wins ? a_reg : b_reg;
                    ov_reg <= a_wins ? va_reg : vb_reg;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/core/sparse_table_range_min_index_unit.sv @@
// ============================================================================
// Sparse-table range-minimum unit
// Loads signed values, builds argmin levels and answers range-minimum queries.
// ============================================================================
// Items enter on the s_axis group: tuser carries the command, tdata the
// position, value and the query bounds. Every item gives exactly one result
// item on the m_axis group with index, value and status.
// The used count is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, the block does not enforce this. A two-entry
// queue separates checking from execution, so a new item is taken, until the
// queue is full, while the back part works or while a result waits. Load,
// rejected and unused items go from the queue straight to the result. A query
// does two table reads, two value reads, then one compare; a build does these
// for each table entry, on the single shared read and compare path of the back
// part. Reset sets the used count to its maximum and clears the built mark;
// the memories hold no defined content until loaded. A stalled m_axis_tready
// holds the result and, once the queue is full, s_axis_tready drops.
// ============================================================================
module sparse_table_range_min_index_unit
    import strmi_pkg::*;
#(
    parameter int MAX_POSITIONS = DefMaxPositions,
    parameter int VALUE_BITS    = DefValueBits
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [IdxW-1:0]                   cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // position, load_value, range_low, range_high (low bits up), zero padded
    input  logic [((3*IdxW+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // cmd
    input  logic [CmdW-1:0]                   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // min_index, min_value, status (low bits up), zero padded
    output logic [((IdxW+VALUE_BITS+StatW+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OW = ((IdxW + VALUE_BITS + StatW + 7) / 8) * 8;

    logic [IdxW-1:0]       used_count;
    logic                  job_valid, job_ready;
    job_t                  job;
    logic [IdxW-1:0]       o_idx;
    logic [VALUE_BITS-1:0] o_val;
    logic [StatW-1:0]      o_st;

    strmi_front #(.MAX_POSITIONS(MAX_POSITIONS), .VALUE_BITS(VALUE_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tuser),
        .in_pos     (s_axis_tdata[IdxW-1:0]),
        .in_value   (s_axis_tdata[IdxW+VALUE_BITS-1:IdxW]),
        .in_lo      (s_axis_tdata[2*IdxW+VALUE_BITS-1:IdxW+VALUE_BITS]),
        .in_hi      (s_axis_tdata[3*IdxW+VALUE_BITS-1:2*IdxW+VALUE_BITS]),
        .used_count (used_count),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job)
    );

    strmi_back #(.MAX_POSITIONS(MAX_POSITIONS), .VALUE_BITS(VALUE_BITS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .used_count (used_count),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_index  (o_idx),
        .out_value  (o_val),
        .out_status (o_st)
    );

    assign m_axis_tdata = OW'({o_st, o_val, o_idx});

endmodule

@@ rtl/core/strmi_checker.sv @@
// ============================================================================
// Sparse-table port checker
// Watches the top-level result ports for handshake and result consistency.
// ============================================================================
module strmi_checker
    import strmi_pkg::*;
#(
    parameter int VALUE_BITS = DefValueBits
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [((IdxW+VALUE_BITS+StatW+7)/8)*8-1:0] m_axis_tdata
);

    logic [IdxW-1:0]  idx;
    logic [StatW-1:0] st;

    assign idx = m_axis_tdata[IdxW-1:0];
    assign st  = m_axis_tdata[IdxW+VALUE_BITS+StatW-1:IdxW+VALUE_BITS];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && st != ST_OK |-> idx == '0)
        else $error("failed item reports an index");

    a_zero_val: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && idx == '0 |->
            m_axis_tdata[IdxW+VALUE_BITS-1:IdxW] == '0)
        else $error("index 0 with nonzero value");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind sparse_table_range_min_index_unit strmi_checker #(.VALUE_BITS(VALUE_BITS)) u_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Range-minimum unit testbench
// Loads value sets, builds the argmin levels and checks query answers,
// rejects and register saturation against an in-bench predictor, with random
// gaps on the input side and random stalls on the result side.
// ============================================================================
module tb_top;
    import strmi_pkg::*;

    localparam int NPOS = 1024;
    localparam int NLVL = 10;
    localparam logic [CmdW-1:0] CMD_NONE = 2'd3;

    typedef struct {
        logic [IdxW-1:0]  idx;
        logic [63:0]      val;
        logic [StatW-1:0] st;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [IdxW-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic [CmdW-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;

    sparse_table_range_min_index_unit u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Predictor state.
    logic signed [63:0] store_val [1:NPOS];
    bit written [1:NPOS];
    int unsigned level_tbl [1:NLVL][1:NPOS];
    bit built;
    int unsigned used_n = NPOS;

    answer_t pending_answers[$];
    int errors = 0;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    int stall_left = 0;

    function automatic int unsigned log2_floor(int unsigned x);
        int unsigned k;
        k = 0;
        while (x > 1) begin
            x = x >> 1;
            k++;
        end
        return k;
    endfunction

    function automatic int unsigned lower_pos(int unsigned a, int unsigned b);
        return (store_val[a] < store_val[b]) ? a : b;
    endfunction

    function automatic int unsigned level_entry(int unsigned k, int unsigned i);
        return (k == 0) ? i : level_tbl[k][i];
    endfunction

    function automatic answer_t predict_min(logic [CmdW-1:0] cmd, int unsigned pos,
                                            logic [63:0] val, int unsigned lo,
                                            int unsigned hi);
        answer_t r;
        int unsigned k, a, b, m, span;
        r.idx = '0;
        r.val = '0;
        r.st = ST_OK;
        case (cmd)
            CMD_LOAD: begin
                if (pos < 1 || pos > used_n) begin
                    r.st = ST_RANGE;
                end else begin
                    store_val[pos] = val;
                    written[pos] = 1'b1;
                    built = 1'b0;
                end
            end
            CMD_BUILD: begin
                for (k = 1; k <= log2_floor(used_n); k++) begin
                    span = 1 << k;
                    for (int unsigned i = 1; i + span <= used_n + 1; i++) begin
                        level_tbl[k][i] = lower_pos(level_entry(k - 1, i),
                                                    level_entry(k - 1, i + span / 2));
                    end
                end
                built = 1'b1;
            end
            CMD_QUERY: begin
                if (!built) begin
                    r.st = ST_NOBUILD;
                end else if (lo > hi) begin
                    r.st = ST_EMPTY;
                end else if (lo < 1 || hi > used_n) begin
                    r.st = ST_RANGE;
                end else begin
                    k = log2_floor(hi - lo + 1);
                    a = level_entry(k, lo);
                    b = level_entry(k, hi - (1 << k) + 1);
                    m = lower_pos(a, b);
                    r.idx = m[IdxW-1:0];
                    r.val = store_val[m];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic bit all_loaded();
        for (int i = 1; i <= used_n; i++) begin
            if (!written[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [63:0] pick_value();
        int unsigned c;
        c = $urandom_range(0, 9);
        if (c == 0) return 64'h8000_0000_0000_0000;
        if (c == 1) return 64'h7FFF_FFFF_FFFF_FFFF;
        if (c < 5) return 64'(signed'($urandom_range(0, 4)) - 2);
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(logic [CmdW-1:0] cmd, int unsigned pos, logic [63:0] val,
                             int unsigned lo, int unsigned hi);
        int unsigned gap, c;
        gap = 0;
        if (gaps_on) begin
            c = $urandom_range(0, 9);
            if (c >= 9) gap = $urandom_range(10, 30);
            else if (c >= 6) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        pending_answers.push_back(predict_min(cmd, pos, val, lo, hi));
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {7'b0, hi[IdxW-1:0], lo[IdxW-1:0], val, pos[IdxW-1:0]};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic write_used_count(logic [IdxW-1:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        used_n = (v < 1) ? 1 : (v > NPOS) ? NPOS : v;
        built = 1'b0;
    endtask

    task automatic test_directed();
        send_item(CMD_QUERY, 0, '0, 1, 1);
        send_item(CMD_NONE, 2047, '1, 2047, 2047);
        write_used_count(11'd0);
        send_item(CMD_LOAD, 0, 64'd7, 0, 0);
        send_item(CMD_LOAD, 1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
        send_item(CMD_LOAD, 2, 64'd3, 0, 0);
        send_item(CMD_BUILD, 0, '0, 0, 0);
        send_item(CMD_QUERY, 0, '0, 1, 1);
        send_item(CMD_QUERY, 0, '0, 2, 1);
        send_item(CMD_QUERY, 0, '0, 0, 1);
        send_item(CMD_QUERY, 0, '0, 1, 2047);
        write_used_count(11'd4);
        send_item(CMD_LOAD, 1, 64'h8000_0000_0000_0000, 0, 0);
        send_item(CMD_LOAD, 2, 64'd5, 0, 0);
        send_item(CMD_LOAD, 3, 64'h8000_0000_0000_0000, 0, 0);
        send_item(CMD_LOAD, 4, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
        send_item(CMD_QUERY, 0, '0, 1, 4);
        send_item(CMD_BUILD, 0, '0, 0, 0);
        send_item(CMD_QUERY, 0, '0, 1, 4);
        send_item(CMD_QUERY, 0, '0, 4, 4);
        send_item(CMD_QUERY, 0, '0, 1, 2);
        send_item(CMD_LOAD, 2047, '0, 0, 0);
        send_item(CMD_QUERY, 0, '0, 2, 4);
        send_item(CMD_LOAD, 4, 64'd0, 0, 0);
        send_item(CMD_QUERY, 0, '0, 1, 4);
    endtask

    task automatic test_full_size();
        write_used_count(11'h7FF);
        send_item(CMD_LOAD, NPOS, pick_value(), 0, 0);
        send_item(CMD_LOAD, NPOS + 1, pick_value(), 0, 0);
        send_item(CMD_QUERY, 0, '0, 1, NPOS);
    endtask

    task automatic test_random_sets();
        int sent;
        int unsigned n, lo, hi, order[$], cmd;
        sent = 0;
        while (sent < 680) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
            write_used_count(n[IdxW-1:0]);
            order.delete();
            for (int p = 1; p <= n; p++) order.push_back(p);
            order.shuffle();
            foreach (order[j]) begin
                send_item(CMD_LOAD, order[j], pick_value(), 0, 0);
                sent++;
            end
            send_item(CMD_BUILD, 0, '0, 0, 0);
            sent++;
            repeat ($urandom_range(8, 20)) begin
                cmd = $urandom_range(0, 9);
                if (cmd < 7) begin
                    lo = $urandom_range(1, n);
                    hi = $urandom_range(lo, n);
                    send_item(CMD_QUERY, 0, '0, lo, hi);
                end else if (cmd == 7) begin
                    send_item(CMD_LOAD, $urandom_range(1, n), pick_value(), 0, 0);
                    send_item(CMD_QUERY, 0, '0, 1, n);
                    send_item(CMD_BUILD, 0, '0, 0, 0);
                    sent += 2;
                end else begin
                    cmd = $urandom_range(0, 3);
                    if (cmd == CMD_BUILD && !all_loaded()) cmd = CMD_NONE;
                    send_item(cmd[CmdW-1:0], $urandom_range(0, 2047), {$urandom, $urandom},
                              $urandom_range(0, 2047), $urandom_range(0, 2047));
                end
                sent++;
            end
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 9) < 3) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    answer_t want;
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                if (m_axis_tdata[10:0] !== want.idx) begin
                    $display("%0t: min_index expected %0d actual %0d",
                             $time, want.idx, m_axis_tdata[10:0]);
                    errors++;
                end
                if (m_axis_tdata[74:11] !== want.val) begin
                    $display("%0t: min_value expected %h actual %h",
                             $time, want.val, m_axis_tdata[74:11]);
                    errors++;
                end
                if (m_axis_tdata[76:75] !== want.st) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.st, m_axis_tdata[76:75]);
                    errors++;
                end
            end
        end
    end

    initial begin
        built = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_size();
        test_random_sets();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending_answers.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/strmi_pkg.sv
rtl/core/strmi_front.sv
rtl/core/strmi_back.sv
rtl/core/sparse_table_range_min_index_unit.sv
rtl/core/strmi_checker.sv
sim/tb_top.sv
